/* src/kdsf_pkg.sv */
`default_nettype none

package kdsf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_LEN_DEF     = 1024;
  localparam int SYMBOL_BITS_DEF = 8;

  // Fixed field widths of the stream payload
  localparam int KIND_W   = 2;
  localparam int SYM_W    = 8;
  localparam int K_W      = 20;
  localparam int START_W  = 10;
  localparam int LENOUT_W = 11;

  // Transaction kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE, S_INIT_RD, S_INIT_WR, S_KEY_RD, S_KEY_A, S_KEY_B,
    S_CI_RD, S_CI_LD, S_CJ_RD, S_CJ_CMP, S_CI_WR, S_STEP,
    S_SA_RD, S_SA_WR, S_K_RD, S_K_RANK, S_K_SA, S_K_TEST, S_K_TJ,
    S_K_EQ, S_K_WR, S_W_RD, S_W_CMP, S_REPORT
  } st_e;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_INIT_RD, OP_INIT_WR, OP_KEY_RD, OP_KEY_A, OP_KEY_B,
    OP_CI_RD, OP_CI_LD, OP_CJ_RD, OP_CJ_CMP, OP_CI_WR, OP_STEP,
    OP_SA_RD, OP_SA_WR, OP_K_RD, OP_K_RANK, OP_K_SA, OP_K_TEST, OP_K_TJ,
    OP_K_EQ, OP_K_WR, OP_W_RD, OP_W_CMP, OP_REPORT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic len_zero;
    logic k_in_zero;
    logic ord_valid;
    logic step_more;
    logic rank_zero;
    logic can_cmp;
    logic ch_eq;
    logic k_fits;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/kdsf_ram.sv */
`default_nettype none

module kdsf_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/kdsf_ctrl.sv */
`default_nettype none

module kdsf_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [kdsf_pkg::KIND_W-1:0] kind_i,
  input  wire kdsf_pkg::sts_t              sts_i,
  output logic                             in_ready_o,
  output kdsf_pkg::cmd_t                   cmd_o
);

  kdsf_pkg::st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kdsf_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = kdsf_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      kdsf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = kdsf_pkg::OP_ACCEPT;
          if (kind_i == kdsf_pkg::KIND_QUERY) begin
            priority if (sts_i.len_zero || sts_i.k_in_zero) state_d = kdsf_pkg::S_REPORT;
            else if (sts_i.ord_valid) state_d = kdsf_pkg::S_W_RD;
            else state_d = kdsf_pkg::S_INIT_RD;
          end
        end
      end
      kdsf_pkg::S_INIT_RD: begin
        cmd_o.op = kdsf_pkg::OP_INIT_RD;
        state_d  = kdsf_pkg::S_INIT_WR;
      end
      kdsf_pkg::S_INIT_WR: begin
        cmd_o.op = kdsf_pkg::OP_INIT_WR;
        state_d  = sts_i.i_last ? kdsf_pkg::S_KEY_RD : kdsf_pkg::S_INIT_RD;
      end
      kdsf_pkg::S_KEY_RD: begin
        cmd_o.op = kdsf_pkg::OP_KEY_RD;
        state_d  = kdsf_pkg::S_KEY_A;
      end
      kdsf_pkg::S_KEY_A: begin
        cmd_o.op = kdsf_pkg::OP_KEY_A;
        state_d  = kdsf_pkg::S_KEY_B;
      end
      kdsf_pkg::S_KEY_B: begin
        cmd_o.op = kdsf_pkg::OP_KEY_B;
        state_d  = sts_i.i_last ? kdsf_pkg::S_CI_RD : kdsf_pkg::S_KEY_RD;
      end
      kdsf_pkg::S_CI_RD: begin
        cmd_o.op = kdsf_pkg::OP_CI_RD;
        state_d  = kdsf_pkg::S_CI_LD;
      end
      kdsf_pkg::S_CI_LD: begin
        cmd_o.op = kdsf_pkg::OP_CI_LD;
        state_d  = kdsf_pkg::S_CJ_RD;
      end
      kdsf_pkg::S_CJ_RD: begin
        cmd_o.op = kdsf_pkg::OP_CJ_RD;
        state_d  = kdsf_pkg::S_CJ_CMP;
      end
      kdsf_pkg::S_CJ_CMP: begin
        cmd_o.op = kdsf_pkg::OP_CJ_CMP;
        state_d  = sts_i.j_last ? kdsf_pkg::S_CI_WR : kdsf_pkg::S_CJ_RD;
      end
      kdsf_pkg::S_CI_WR: begin
        cmd_o.op = kdsf_pkg::OP_CI_WR;
        state_d  = sts_i.i_last ? kdsf_pkg::S_STEP : kdsf_pkg::S_CI_RD;
      end
      kdsf_pkg::S_STEP: begin
        cmd_o.op = kdsf_pkg::OP_STEP;
        state_d  = sts_i.step_more ? kdsf_pkg::S_KEY_RD : kdsf_pkg::S_SA_RD;
      end
      kdsf_pkg::S_SA_RD: begin
        cmd_o.op = kdsf_pkg::OP_SA_RD;
        state_d  = kdsf_pkg::S_SA_WR;
      end
      kdsf_pkg::S_SA_WR: begin
        cmd_o.op = kdsf_pkg::OP_SA_WR;
        state_d  = sts_i.i_last ? kdsf_pkg::S_K_RD : kdsf_pkg::S_SA_RD;
      end
      kdsf_pkg::S_K_RD: begin
        cmd_o.op = kdsf_pkg::OP_K_RD;
        state_d  = kdsf_pkg::S_K_RANK;
      end
      kdsf_pkg::S_K_RANK: begin
        cmd_o.op = kdsf_pkg::OP_K_RANK;
        priority if (!sts_i.rank_zero) state_d = kdsf_pkg::S_K_SA;
        else if (sts_i.i_last) state_d = kdsf_pkg::S_W_RD;
        else state_d = kdsf_pkg::S_K_RD;
      end
      kdsf_pkg::S_K_SA: begin
        cmd_o.op = kdsf_pkg::OP_K_SA;
        state_d  = kdsf_pkg::S_K_TEST;
      end
      kdsf_pkg::S_K_TEST: begin
        cmd_o.op = kdsf_pkg::OP_K_TEST;
        state_d  = sts_i.can_cmp ? kdsf_pkg::S_K_TJ : kdsf_pkg::S_K_WR;
      end
      kdsf_pkg::S_K_TJ: begin
        cmd_o.op = kdsf_pkg::OP_K_TJ;
        state_d  = kdsf_pkg::S_K_EQ;
      end
      kdsf_pkg::S_K_EQ: begin
        cmd_o.op = kdsf_pkg::OP_K_EQ;
        state_d  = sts_i.ch_eq ? kdsf_pkg::S_K_TEST : kdsf_pkg::S_K_WR;
      end
      kdsf_pkg::S_K_WR: begin
        cmd_o.op = kdsf_pkg::OP_K_WR;
        state_d  = sts_i.i_last ? kdsf_pkg::S_W_RD : kdsf_pkg::S_K_RD;
      end
      kdsf_pkg::S_W_RD: begin
        cmd_o.op = kdsf_pkg::OP_W_RD;
        state_d  = kdsf_pkg::S_W_CMP;
      end
      kdsf_pkg::S_W_CMP: begin
        cmd_o.op = kdsf_pkg::OP_W_CMP;
        state_d  = (sts_i.k_fits || sts_i.i_last) ? kdsf_pkg::S_REPORT : kdsf_pkg::S_W_RD;
      end
      kdsf_pkg::S_REPORT: begin
        cmd_o.op = kdsf_pkg::OP_REPORT;
        if (sts_i.out_free) state_d = kdsf_pkg::S_IDLE;
      end
      default: state_d = kdsf_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/kdsf_dp.sv */
`default_nettype none

module kdsf_dp #(
  parameter int MAX_LEN     = kdsf_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = kdsf_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire kdsf_pkg::cmd_t                cmd_i,
  input  wire logic [kdsf_pkg::KIND_W-1:0]   kind_i,
  input  wire logic [kdsf_pkg::SYM_W-1:0]    symbol_i,
  input  wire logic [kdsf_pkg::K_W-1:0]      wanted_rank_i,
  output kdsf_pkg::sts_t                     sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               found_o,
  output logic [kdsf_pkg::START_W-1:0]       start_pos_o,
  output logic [kdsf_pkg::LENOUT_W-1:0]      sub_length_o
);

  localparam int AW  = $clog2(MAX_LEN);
  localparam int LW  = AW + 1;
  localparam int SB  = SYMBOL_BITS;
  localparam int RW  = (AW > SB) ? AW : SB;
  localparam int KBW = RW + 1;
  localparam int KW  = kdsf_pkg::K_W;
  localparam int SW  = kdsf_pkg::START_W;
  localparam int OLW = kdsf_pkg::LENOUT_W;

  // Control and work registers
  logic [LW-1:0] len_q;
  logic          valid_q;
  logic [AW-1:0] i_q, j_q, cnt_q, r_q;
  logic [LW-1:0] h_q, step_q;
  logic [KW-1:0] k_q;
  logic [RW-1:0] ka_q;
  logic [KBW-1:0] kb_q;
  logic [SB-1:0] tch_q;
  logic          res_found_q;
  logic [SW-1:0] res_start_q;
  logic [OLW-1:0] res_len_q;
  logic          out_valid_q, found_q;
  logic [SW-1:0] start_q;
  logic [OLW-1:0] length_q;

  // Memory ports
  logic          t_we, r_we, a_we, b_we, s_we, l_we;
  logic [AW-1:0] t_wa, r_wa, a_wa, b_wa, s_wa, l_wa;
  logic [AW-1:0] t_ra, r_ra, ab_ra, s_ra, l_ra;
  logic [SB-1:0] t_wd, text_rd;
  logic [RW-1:0] r_wd, rank_rd, ka_rd;
  logic [KBW-1:0] b_wd, kb_rd;
  logic [AW-1:0] s_wd, sa_rd, l_wd, lcp_rd;

  kdsf_ram #(.W(SB), .D(MAX_LEN)) u_text (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(text_rd));
  kdsf_ram #(.W(RW), .D(MAX_LEN)) u_rank (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(rank_rd));
  kdsf_ram #(.W(RW), .D(MAX_LEN)) u_keya (
    .clk_i, .we_i(a_we), .waddr_i(a_wa), .wdata_i(rank_rd), .raddr_i(ab_ra), .rdata_o(ka_rd));
  kdsf_ram #(.W(KBW), .D(MAX_LEN)) u_keyb (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(ab_ra), .rdata_o(kb_rd));
  kdsf_ram #(.W(AW), .D(MAX_LEN)) u_sa (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(sa_rd));
  kdsf_ram #(.W(AW), .D(MAX_LEN)) u_lcp (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(lcp_rd));

  // Derived values
  logic [LW-1:0] i_step, i_h, j_h, fresh;
  logic [AW-1:0] i_adv, j_adv;
  logic          room, accept, key_less, step_in, out_load;
  logic [KW:0]   len_sum;

  assign accept   = (cmd_i.op == kdsf_pkg::OP_ACCEPT);
  assign room     = (len_q < LW'(MAX_LEN));
  assign i_step   = LW'(i_q) + step_q;
  assign i_h      = LW'(i_q) + h_q;
  assign j_h      = LW'(j_q) + h_q;
  assign step_in  = (i_step < len_q);
  assign i_adv    = sts_o.i_last ? '0 : i_q + AW'(1);
  assign j_adv    = sts_o.j_last ? '0 : j_q + AW'(1);
  assign key_less = (ka_rd < ka_q) || ((ka_rd == ka_q) && (kb_rd < kb_q));
  assign fresh    = len_q - LW'(sa_rd) - LW'(lcp_rd);
  assign len_sum  = (KW+1)'(lcp_rd) + (KW+1)'(k_q);
  assign out_load = (cmd_i.op == kdsf_pkg::OP_REPORT) && sts_o.out_free;

  // Status to the controller
  always_comb begin
    sts_o.i_last    = (LW'(i_q) + LW'(1) == len_q);
    sts_o.j_last    = (LW'(j_q) + LW'(1) == len_q);
    sts_o.len_zero  = (len_q == '0);
    sts_o.k_in_zero = (wanted_rank_i == '0);
    sts_o.ord_valid = valid_q;
    sts_o.step_more = ((step_q << 1) < len_q);
    sts_o.rank_zero = (rank_rd == '0);
    sts_o.can_cmp   = (i_h < len_q) && (j_h < len_q);
    sts_o.ch_eq     = (text_rd == tch_q);
    sts_o.k_fits    = (k_q <= KW'(fresh));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Memory address and write selection
  always_comb begin
    t_we = 1'b0; t_wa = len_q[AW-1:0]; t_wd = SB'(symbol_i); t_ra = i_q;
    r_we = 1'b0; r_wa = i_q; r_wd = RW'(text_rd); r_ra = i_q;
    a_we = 1'b0; a_wa = i_q;
    b_we = 1'b0; b_wa = i_q; b_wd = step_in ? (KBW'(rank_rd) + KBW'(1)) : '0;
    ab_ra = i_q;
    s_we = 1'b0; s_wa = rank_rd[AW-1:0]; s_wd = i_q; s_ra = i_q;
    l_we = 1'b0; l_wa = r_q; l_wd = h_q[AW-1:0]; l_ra = i_q;
    unique case (cmd_i.op)
      kdsf_pkg::OP_ACCEPT: t_we = (kind_i == kdsf_pkg::KIND_APPEND) && room;
      kdsf_pkg::OP_INIT_WR: r_we = 1'b1;
      kdsf_pkg::OP_KEY_A: begin
        a_we = 1'b1;
        r_ra = i_step[AW-1:0];
      end
      kdsf_pkg::OP_KEY_B: b_we = 1'b1;
      kdsf_pkg::OP_CJ_RD: ab_ra = j_q;
      kdsf_pkg::OP_CI_WR: begin
        r_we = 1'b1;
        r_wd = RW'(cnt_q);
      end
      kdsf_pkg::OP_SA_WR: s_we = 1'b1;
      kdsf_pkg::OP_K_RANK: begin
        s_ra = rank_rd[AW-1:0] - AW'(1);
        if (rank_rd == '0) begin
          l_we = 1'b1;
          l_wa = '0;
          l_wd = '0;
        end
      end
      kdsf_pkg::OP_K_TEST: t_ra = i_h[AW-1:0];
      kdsf_pkg::OP_K_TJ: t_ra = j_h[AW-1:0];
      kdsf_pkg::OP_K_WR: l_we = 1'b1;
      default: ;
    endcase
  end

  // Text length, table state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && (kind_i == kdsf_pkg::KIND_APPEND) && room) begin
        len_q   <= len_q + LW'(1);
        valid_q <= 1'b0;
      end
      if (accept && (kind_i == kdsf_pkg::KIND_CLEAR)) begin
        len_q   <= '0;
        valid_q <= 1'b0;
      end
      if (((cmd_i.op == kdsf_pkg::OP_K_WR) ||
           ((cmd_i.op == kdsf_pkg::OP_K_RANK) && sts_o.rank_zero)) && sts_o.i_last) begin
        valid_q <= 1'b1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      found_q  <= res_found_q;
      start_q  <= res_start_q;
      length_q <= res_len_q;
    end
    unique case (cmd_i.op)
      kdsf_pkg::OP_ACCEPT: begin
        k_q         <= wanted_rank_i;
        i_q         <= '0;
        h_q         <= '0;
        step_q      <= LW'(1);
        res_found_q <= 1'b0;
        res_start_q <= '0;
        res_len_q   <= '0;
      end
      kdsf_pkg::OP_INIT_WR, kdsf_pkg::OP_KEY_B, kdsf_pkg::OP_CI_WR,
      kdsf_pkg::OP_SA_WR: i_q <= i_adv;
      kdsf_pkg::OP_CI_LD: begin
        ka_q  <= ka_rd;
        kb_q  <= kb_rd;
        j_q   <= '0;
        cnt_q <= '0;
      end
      kdsf_pkg::OP_CJ_CMP: begin
        if (key_less) cnt_q <= cnt_q + AW'(1);
        j_q <= j_adv;
      end
      kdsf_pkg::OP_STEP: step_q <= step_q << 1;
      kdsf_pkg::OP_K_RANK: begin
        r_q <= rank_rd[AW-1:0];
        if (rank_rd == '0) i_q <= i_adv;
      end
      kdsf_pkg::OP_K_SA: j_q <= sa_rd;
      kdsf_pkg::OP_K_TJ: tch_q <= text_rd;
      kdsf_pkg::OP_K_EQ: if (sts_o.ch_eq) h_q <= h_q + LW'(1);
      kdsf_pkg::OP_K_WR: begin
        if (h_q != '0) h_q <= h_q - LW'(1);
        i_q <= i_adv;
      end
      kdsf_pkg::OP_W_CMP: begin
        if (sts_o.k_fits) begin
          res_found_q <= 1'b1;
          res_start_q <= SW'(sa_rd);
          res_len_q   <= OLW'(len_sum);
        end else begin
          k_q <= k_q - KW'(fresh);
          i_q <= i_adv;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign start_pos_o  = start_q;
  assign sub_length_o = length_q;

  a_len_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(MAX_LEN)) else $error("text length above capacity");

  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == kdsf_pkg::KIND_APPEND) && room)
      |=> (len_q == $past(len_q) + LW'(1)) && !valid_q)
    else $error("append did not grow text or keep tables stale");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == kdsf_pkg::KIND_CLEAR)) |=> (len_q == '0) && !valid_q)
    else $error("clear did not empty text");

  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (start_q == '0) && (length_q == '0))
    else $error("miss result carries nonzero fields");

endmodule

`default_nettype wire

/* src/kth_distinct_substring_finder.sv */
`default_nettype none

// Channel   Dir  Fields (low bit up)
// s_axis    in   tuser: kind[1:0]; tdata: symbol[7:0], wanted_rank[27:8]
// m_axis    out  tuser: found[0];  tdata: start_pos[9:0], sub_length[20:10]
//
// Append, clear and unused kinds are taken in idle. A query on fresh tables
// walks the suffixes in sorted order until the rank fits. After the text changed,
// the first query rebuilds: it loads the ranks, then runs the doubling passes,
// ceil(log2 n) of them but at least one, each a key-count sweep over one RAM
// read port, then builds the suffix and LCP tables, comparing characters
// one at a time for each LCP entry.
// Reset empties the text; no clearing pass. The input is held off during a
// query; a result waiting on m_axis stalls only the next query report.
module kth_distinct_substring_finder #(
  parameter int MAX_LEN     = kdsf_pkg::MAX_LEN_DEF,
  parameter int SYMBOL_BITS = kdsf_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // symbol[7:0], wanted_rank[27:8]
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // start_pos[9:0], sub_length[20:10]
  output logic [0:0]       m_axis_tuser    // found[0]
);

  kdsf_pkg::cmd_t cmd;
  kdsf_pkg::sts_t sts;
  logic           found;
  logic [kdsf_pkg::START_W-1:0]  start_pos;
  logic [kdsf_pkg::LENOUT_W-1:0] sub_length;

  kdsf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .kind_i     (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  kdsf_dp #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .kind_i        (s_axis_tuser),
    .symbol_i      (s_axis_tdata[7:0]),
    .wanted_rank_i (s_axis_tdata[27:8]),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .found_o       (found),
    .start_pos_o   (start_pos),
    .sub_length_o  (sub_length)
  );

  assign m_axis_tuser = found;
  assign m_axis_tdata = {3'b000, sub_length, start_pos};

endmodule

`default_nettype wire

/* tb/kth_distinct_substring_finder_tb.sv */
`default_nettype none

module kth_distinct_substring_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_MAX = kdsf_pkg::MAX_LEN_DEF;
  localparam logic [kdsf_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    bit                          found;
    bit [kdsf_pkg::START_W-1:0]  start_pos;
    bit [kdsf_pkg::LENOUT_W-1:0] sub_length;
  } answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata;
  logic [1:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  // Predictor state: a shadow copy of the text and the expected answers
  bit [kdsf_pkg::SYM_W-1:0] text_q[$];
  answer_t                  answer_q[$];

  int  n_errors;
  int  n_sent;
  int  n_queries;
  int  n_hits;
  int  n_checked;
  bit  quiet_mode;     // no idling on either side
  bit  hold_request;   // receiver long hold-off

  kth_distinct_substring_finder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Suffix a sorts before suffix b; running off the end sorts lowest
  function automatic bit suffix_before(int a, int b);
    int n;
    n = text_q.size();
    while (a < n && b < n) begin
      if (text_q[a] != text_q[b]) return text_q[a] < text_q[b];
      a++;
      b++;
    end
    return a >= n;
  endfunction

  function automatic int common_prefix(int a, int b);
    int n;
    int h;
    n = text_q.size();
    h = 0;
    while (a + h < n && b + h < n && text_q[a + h] == text_q[b + h]) h++;
    return h;
  endfunction

  // k-th distinct substring in lexicographic order
  function automatic answer_t kth_substring(bit [kdsf_pkg::K_W-1:0] k_in);
    answer_t res;
    int      order[$];
    int      n;
    int      pos;
    int      tmp;
    int      lcp;
    longint  remain;
    longint  fresh;
    n = text_q.size();
    res.found = 0;
    res.start_pos = '0;
    res.sub_length = '0;
    if (n == 0 || k_in == 0) return res;
    for (int i = 0; i < n; i++) order.push_back(i);
    // insertion sort of suffix starts
    for (int i = 1; i < n; i++) begin
      tmp = order[i];
      pos = i;
      while (pos > 0 && suffix_before(tmp, order[pos - 1])) begin
        order[pos] = order[pos - 1];
        pos--;
      end
      order[pos] = tmp;
    end
    remain = k_in;
    for (int i = 0; i < n; i++) begin
      lcp = (i == 0) ? 0 : common_prefix(order[i], order[i - 1]);
      fresh = n - order[i] - lcp;
      if (remain > fresh) begin
        remain -= fresh;
      end else begin
        res.found = 1;
        res.start_pos = order[i];
        res.sub_length = lcp + remain;
        return res;
      end
    end
    return res;
  endfunction

  // Predict the effect of one accepted transaction
  function automatic void apply_item(logic [1:0] kind, logic [kdsf_pkg::SYM_W-1:0] sym,
                                     logic [kdsf_pkg::K_W-1:0] k);
    case (kind)
      kdsf_pkg::KIND_APPEND: begin
        if (text_q.size() < TEXT_MAX) text_q.push_back(sym);
      end
      kdsf_pkg::KIND_CLEAR: begin
        text_q.delete();
      end
      kdsf_pkg::KIND_QUERY: begin
        answer_q.push_back(kth_substring(k));
        n_queries++;
      end
      default: ;
    endcase
  endfunction

  // Send one transaction and wait for acceptance
  task automatic send_item(logic [1:0] kind, logic [kdsf_pkg::SYM_W-1:0] sym,
                           logic [kdsf_pkg::K_W-1:0] k);
    if (!quiet_mode && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, k, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(kind, sym, k);
    n_sent++;
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(kdsf_pkg::KIND_APPEND, s[i], $urandom);
  endtask

  // Receiver ready: random idling, long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (4000) @(posedge clk_i);
        hold_request = 0;
      end
      m_axis_tready <= quiet_mode || ($urandom_range(99) >= 19);
    end
  end

  // Result checker
  initial begin
    answer_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (answer_q.size() == 0) begin
          $error("result with no query outstanding");
          n_errors++;
        end else begin
          want = answer_q.pop_front();
          n_checked++;
          if (want.found) n_hits++;
          if (m_axis_tuser[0] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, m_axis_tuser[0]);
            n_errors++;
          end
          if (m_axis_tdata[9:0] !== want.start_pos) begin
            $error("start_pos: expected %0d, got %0d", want.start_pos,
                   m_axis_tdata[9:0]);
            n_errors++;
          end
          if (m_axis_tdata[20:10] !== want.sub_length) begin
            $error("sub_length: expected %0d, got %0d", want.sub_length,
                   m_axis_tdata[20:10]);
            n_errors++;
          end
        end
      end
    end
  end

  // Empty text, rank zero, extremes of the fields, unused kind
  task automatic test_directed();
    send_item(kdsf_pkg::KIND_QUERY, 8'h00, 20'd1);
    send_item(KIND_UNUSED, 8'hFF, 20'hFFFFF);
    send_item(kdsf_pkg::KIND_QUERY, 8'hFF, 20'd0);
    append_text("abab");
    for (int k = 0; k <= 9; k++) send_item(kdsf_pkg::KIND_QUERY, 8'h00, k);
    send_item(kdsf_pkg::KIND_QUERY, 8'h00, 20'hFFFFF);
    send_item(kdsf_pkg::KIND_APPEND, 8'hFF, 20'hFFFFF);
    send_item(kdsf_pkg::KIND_APPEND, 8'h00, 20'h00000);
    send_item(KIND_UNUSED, 8'h55, 20'd3);
    send_item(kdsf_pkg::KIND_QUERY, 8'h00, 20'd1);
    send_item(kdsf_pkg::KIND_QUERY, 8'h00, 20'd15);
    send_item(kdsf_pkg::KIND_CLEAR, 8'hAA, 20'h55555);
    send_item(kdsf_pkg::KIND_QUERY, 8'h00, 20'd1);
  endtask

  // Fill past capacity; the surplus appends are dropped, then a clear
  task automatic test_full_store();
    send_item(kdsf_pkg::KIND_CLEAR, 8'h00, 20'd0);
    for (int i = 0; i < TEXT_MAX + 6; i++)
      send_item(kdsf_pkg::KIND_APPEND, $urandom, $urandom);
    send_item(kdsf_pkg::KIND_CLEAR, 8'h00, 20'd0);
    append_text("zz");
    send_item(kdsf_pkg::KIND_QUERY, 8'h00, 20'd2);
  endtask

  // Result port held off while queries keep coming
  task automatic test_backpressure();
    send_item(kdsf_pkg::KIND_CLEAR, 8'h00, 20'd0);
    append_text("mississippi");
    hold_request = 1;
    for (int k = 1; k <= 12; k++) send_item(kdsf_pkg::KIND_QUERY, 8'h00, k * 5);
  endtask

  // Random texts with bursts of queries
  task automatic test_random(int target);
    int len;
    int total;
    int first;
    bit narrow;
    first = n_sent;
    while (n_sent < target) begin
      quiet_mode = (n_sent > first + 60 && n_sent < first + 200);
      send_item(kdsf_pkg::KIND_CLEAR, $urandom, $urandom);
      len = ($urandom_range(9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
      narrow = $urandom_range(1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(29) == 0) send_item(KIND_UNUSED, $urandom, $urandom);
        send_item(kdsf_pkg::KIND_APPEND, narrow ? 8'h61 + $urandom_range(2) : $urandom,
                  $urandom);
      end
      total = text_q.size() * (text_q.size() + 1) / 2;
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(19))
          0: send_item(kdsf_pkg::KIND_QUERY, $urandom, 20'd0);
          1: send_item(kdsf_pkg::KIND_QUERY, $urandom, $urandom);
          default: send_item(kdsf_pkg::KIND_QUERY, $urandom, $urandom_range(1, total + 2));
        endcase
      end
      if ($urandom_range(3) == 0) begin
        // grow the text after a query so the tables must be rebuilt
        send_item(kdsf_pkg::KIND_APPEND, $urandom, $urandom);
        send_item(kdsf_pkg::KIND_QUERY, $urandom, $urandom_range(1, total + 4));
      end
    end
    quiet_mode = 0;
  endtask

  // Main sequence
  initial begin
    int waited;
    n_errors = 0;
    n_sent = 0;
    n_queries = 0;
    n_hits = 0;
    n_checked = 0;
    quiet_mode = 0;
    hold_request = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_store();
    test_backpressure();
    test_random(1450);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (answer_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (200) @(posedge clk_i);
    if (answer_q.size() != 0) begin
      $error("%0d query results never arrived", answer_q.size());
      n_errors++;
    end

    $display("Sent %0d transactions, %0d queries; %0d results checked, %0d found.",
             n_sent, n_queries, n_checked, n_hits);
    $display("Covered empty text, rank zero and overflow, full store, unused kind, hold-off.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
